// File: rtl/mtsed_pkg.sv
// Shared types and constants for the multitouch slot event decoder.
// Used by mtsed_cfg, mtsed_map and multitouch_slot_event_decoder; no dependencies.

package mtsed_pkg;

    localparam int SLOTS_DEFAULT = 16;

    // Event field widths
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int S_TDATA_W = ((TYPE_W + CODE_W + VALUE_W + 7) / 8) * 8;

    // Result field widths
    localparam int PTR_W     = 17;
    localparam int CNT_OUT_W = 5;
    localparam int COUNT_MAX = 31;
    localparam int M_TDATA_W = ((2 * PTR_W + CNT_OUT_W + 7) / 8) * 8;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Event codes
    localparam logic [TYPE_W-1:0] TYPE_ABS    = 16'h0003;
    localparam logic [TYPE_W-1:0] TYPE_SYN    = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_SLOT   = 16'h002f;
    localparam logic [CODE_W-1:0] CODE_TRACK  = 16'h0039;
    localparam logic [CODE_W-1:0] CODE_POSX   = 16'h0035;
    localparam logic [CODE_W-1:0] CODE_POSY   = 16'h0036;
    localparam logic [CODE_W-1:0] CODE_REPORT = 16'h0000;

    // Tracking id that releases a slot
    localparam logic signed [VALUE_W-1:0] TRACK_RELEASE = -32'sd1;

    typedef enum logic [2:0] {
        REG_TOUCH_SCALE_X   = 3'd0,
        REG_TOUCH_SCALE_Y   = 3'd1,
        REG_INVERSE_SCALE_X = 3'd2,
        REG_INVERSE_SCALE_Y = 3'd3,
        REG_ROTATION        = 3'd4,
        REG_ALT_MAPPING     = 3'd5,
        REG_SCREEN_WIDTH    = 3'd6,
        REG_SCREEN_HEIGHT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] touch_scale_x;
        logic [15:0] touch_scale_y;
        logic [15:0] inverse_scale_x;
        logic [15:0] inverse_scale_y;
        logic [1:0]  rotation;
        logic        alternate_mapping;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
    } cfg_t;

endpackage

// File: rtl/mtsed_cfg.sv
// APB configuration registers of the multitouch slot event decoder.
// Depends on mtsed_pkg for the register map and the cfg_t bundle.

module mtsed_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mtsed_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mtsed_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mtsed_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    output mtsed_pkg::cfg_t                      cfg
);

    mtsed_pkg::cfg_t   cfg_reg;
    mtsed_pkg::cfg_t   cfg_next;
    mtsed_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = mtsed_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                mtsed_pkg::REG_TOUCH_SCALE_X:   cfg_next.touch_scale_x     = pwdata[15:0];
                mtsed_pkg::REG_TOUCH_SCALE_Y:   cfg_next.touch_scale_y     = pwdata[15:0];
                mtsed_pkg::REG_INVERSE_SCALE_X: cfg_next.inverse_scale_x   = pwdata[15:0];
                mtsed_pkg::REG_INVERSE_SCALE_Y: cfg_next.inverse_scale_y   = pwdata[15:0];
                mtsed_pkg::REG_ROTATION:        cfg_next.rotation          = pwdata[1:0];
                mtsed_pkg::REG_ALT_MAPPING:     cfg_next.alternate_mapping = pwdata[0];
                mtsed_pkg::REG_SCREEN_WIDTH:    cfg_next.screen_width      = pwdata[12:0];
                mtsed_pkg::REG_SCREEN_HEIGHT:   cfg_next.screen_height     = pwdata[12:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_scale_x     <= 16'd16384;
            cfg_reg.touch_scale_y     <= 16'd16384;
            cfg_reg.inverse_scale_x   <= 16'd4096;
            cfg_reg.inverse_scale_y   <= 16'd4096;
            cfg_reg.rotation          <= 2'd0;
            cfg_reg.alternate_mapping <= 1'b0;
            cfg_reg.screen_width      <= 13'd0;
            cfg_reg.screen_height     <= 13'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            mtsed_pkg::REG_TOUCH_SCALE_X:   prdata = 32'(cfg_reg.touch_scale_x);
            mtsed_pkg::REG_TOUCH_SCALE_Y:   prdata = 32'(cfg_reg.touch_scale_y);
            mtsed_pkg::REG_INVERSE_SCALE_X: prdata = 32'(cfg_reg.inverse_scale_x);
            mtsed_pkg::REG_INVERSE_SCALE_Y: prdata = 32'(cfg_reg.inverse_scale_y);
            mtsed_pkg::REG_ROTATION:        prdata = 32'(cfg_reg.rotation);
            mtsed_pkg::REG_ALT_MAPPING:     prdata = 32'(cfg_reg.alternate_mapping);
            mtsed_pkg::REG_SCREEN_WIDTH:    prdata = 32'(cfg_reg.screen_width);
            mtsed_pkg::REG_SCREEN_HEIGHT:   prdata = 32'(cfg_reg.screen_height);
            default:                        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/mtsed_map.sv
// Touch-to-screen scaling and orientation mapping for one report word.
// Depends on mtsed_pkg for cfg_t and the pointer width.

module mtsed_map
(
    input  logic signed [31:0]                     slot_x,
    input  logic signed [31:0]                     slot_y,
    input  mtsed_pkg::cfg_t                        cfg,
    output logic signed [mtsed_pkg::PTR_W-1:0]     pointer_x,
    output logic signed [mtsed_pkg::PTR_W-1:0]     pointer_y
);

    // v * f / 2^12, truncated toward zero
    function automatic logic signed [37:0] scale_q12(logic signed [31:0] v, logic [15:0] f);
        logic signed [48:0] a;
        logic signed [48:0] b;
        logic signed [48:0] prod;
        logic signed [48:0] adj;
        logic signed [48:0] shifted;
        a       = v;
        b       = $signed({33'd0, f});
        prod    = a * b;
        adj     = prod + (prod[48] ? 49'sd4095 : 49'sd0);
        shifted = adj >>> 12;
        return shifted[37:0];
    endfunction

    function automatic logic signed [mtsed_pkg::PTR_W-1:0] sat_ptr(logic signed [37:0] v);
        if (v > 38'sd65535)
            return 17'sh0FFFF;
        else if (v < -38'sd65536)
            return 17'sh10000;
        else
            return v[16:0];
    endfunction

    logic signed [37:0] xt;
    logic signed [37:0] yt;
    logic signed [37:0] w;
    logic signed [37:0] h;
    logic signed [37:0] px;
    logic signed [37:0] py;

    assign xt = scale_q12(slot_x, cfg.inverse_scale_x);
    assign yt = scale_q12(slot_y, cfg.inverse_scale_y);
    assign w  = $signed({25'd0, cfg.screen_width});
    assign h  = $signed({25'd0, cfg.screen_height});

    always_comb
    begin
        if (cfg.alternate_mapping)
        begin
            case (cfg.rotation)
                2'd1:    begin px = xt;     py = yt;     end
                2'd2:    begin px = h - xt; py = yt;     end
                2'd3:    begin px = h - xt; py = w - yt; end
                default: begin px = h - yt; py = xt;     end
            endcase
        end
        else
        begin
            case (cfg.rotation)
                2'd1:    begin px = yt;     py = h - xt; end
                2'd2:    begin px = h - xt; py = w - yt; end
                2'd3:    begin px = w - yt; py = xt;     end
                default: begin px = xt;     py = yt;     end
            endcase
        end
    end

    assign pointer_x = sat_ptr(px);
    assign pointer_y = sat_ptr(py);

endmodule

// File: rtl/multitouch_slot_event_decoder.sv
// Multitouch slot event decoder: one input word per cycle, with no bubbles, while no
// report is stalled. Each accepted word sits in an input register, is decoded against
// the slot table from there and, if it is a sync report, lands in the result register,
// which drives m_tvalid. A report that finds the result register full and stalled waits
// in the input register, and s_tready stays low until m_tready frees it; other words
// keep flowing while a result waits. The x and y positions live in SLOTS-deep memories
// that are read through a register at the slot the next word will use, with a bypass
// for a position written in the same cycle; per-entry valid bits make unwritten
// positions read as zero. Other events update the table and give no result. The user
// must write the configuration over the APB port only while idle; the block does not
// enforce this. Depends on mtsed_pkg, mtsed_cfg and mtsed_map.

module multitouch_slot_event_decoder
#(
    parameter int SLOTS = mtsed_pkg::SLOTS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // event_type[15:0], event_code[31:16], event_value[63:32]
    input  logic [mtsed_pkg::S_TDATA_W-1:0]      s_tdata,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pointer_x[16:0], pointer_y[33:17], contact_count[38:34], zero pad above
    output logic [mtsed_pkg::M_TDATA_W-1:0]      m_tdata,
    // pointer_down[0]
    output logic                                 m_tuser,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mtsed_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mtsed_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mtsed_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CNT_EXT_W = (CNT_W > mtsed_pkg::CNT_OUT_W) ? CNT_W : mtsed_pkg::CNT_OUT_W;
    localparam int PTR_W     = mtsed_pkg::PTR_W;
    localparam int CNT_OUT_W = mtsed_pkg::CNT_OUT_W;

    // v * f / 2^14 truncated toward zero, saturated to 32 bits signed
    function automatic logic signed [31:0] scale_sat32(logic signed [31:0] v, logic [15:0] f);
        logic signed [48:0] a;
        logic signed [48:0] b;
        logic signed [48:0] prod;
        logic signed [48:0] adj;
        logic signed [34:0] q;
        a    = v;
        b    = $signed({33'd0, f});
        prod = a * b;
        adj  = prod + (prod[48] ? 49'sd16383 : 49'sd0);
        q    = adj[48:14];
        if (q[34:31] == 4'b0000 || q[34:31] == 4'b1111)
            return q[31:0];
        else if (q[34])
            return 32'sh8000_0000;
        else
            return 32'sh7FFF_FFFF;
    endfunction

    mtsed_pkg::cfg_t cfg;

    mtsed_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register
    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [15:0]               in_type_reg;
    logic [15:0]               in_code_reg;
    logic signed [31:0]        in_value_reg;

    // Slot table state
    logic [SLOT_W-1:0]         cur_slot_reg;
    logic [SLOT_W-1:0]         cur_slot_next;
    logic [SLOTS-1:0]          slot_down_reg;
    logic [SLOTS-1:0]          slot_down_next;
    logic [SLOTS-1:0]          x_valid_reg;
    logic [SLOTS-1:0]          y_valid_reg;
    logic [CNT_W-1:0]          contacts_reg;
    logic [CNT_W-1:0]          contacts_next;
    logic signed [31:0]        slot_x_mem [SLOTS];
    logic signed [31:0]        slot_y_mem [SLOTS];
    logic signed [31:0]        rd_x_reg;
    logic signed [31:0]        rd_y_reg;
    logic                      rd_xv_reg;
    logic                      rd_yv_reg;

    // Result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [PTR_W-1:0]   out_x_reg;
    logic signed [PTR_W-1:0]   out_y_reg;
    logic                      out_down_reg;
    logic [CNT_OUT_W-1:0]      out_count_reg;

    logic                      s_accept;
    logic                      out_free;
    logic                      fire;
    logic                      is_abs;
    logic                      is_report;
    logic                      ev_slot;
    logic                      ev_track;
    logic                      wr_x;
    logic                      wr_y;
    logic                      slot_ok;
    logic                      track_now;
    logic                      down_cur;
    logic signed [31:0]        wd_x;
    logic signed [31:0]        wd_y;
    logic signed [31:0]        cur_x;
    logic signed [31:0]        cur_y;
    logic signed [PTR_W-1:0]   map_x;
    logic signed [PTR_W-1:0]   map_y;
    logic [CNT_EXT_W-1:0]      cnt_ext;
    logic [CNT_OUT_W-1:0]      count_sat;

    // Handshake
    assign is_abs    = (in_type_reg == mtsed_pkg::TYPE_ABS);
    assign is_report = (in_type_reg == mtsed_pkg::TYPE_SYN) &&
                       (in_code_reg == mtsed_pkg::CODE_REPORT);
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && (!is_report || out_free);
    assign s_tready  = !in_valid_reg || fire;
    assign s_accept  = s_tvalid && s_tready;

    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_type_reg  <= s_tdata[15:0];
            in_code_reg  <= s_tdata[31:16];
            in_value_reg <= $signed(s_tdata[63:32]);
        end
    end

    // Decode
    assign ev_slot   = is_abs && (in_code_reg == mtsed_pkg::CODE_SLOT);
    assign ev_track  = is_abs && (in_code_reg == mtsed_pkg::CODE_TRACK);
    assign wr_x      = fire && is_abs && (in_code_reg == mtsed_pkg::CODE_POSX);
    assign wr_y      = fire && is_abs && (in_code_reg == mtsed_pkg::CODE_POSY);
    assign slot_ok   = !in_value_reg[31] && (in_value_reg < 32'(SLOTS));
    assign track_now = (in_value_reg != mtsed_pkg::TRACK_RELEASE);
    assign down_cur  = slot_down_reg[cur_slot_reg];
    assign wd_x      = scale_sat32(in_value_reg, cfg.touch_scale_x);
    assign wd_y      = scale_sat32(in_value_reg, cfg.touch_scale_y);

    assign cur_slot_next = (fire && ev_slot && slot_ok) ? in_value_reg[SLOT_W-1:0]
                                                         : cur_slot_reg;

    always_comb
    begin
        slot_down_next = slot_down_reg;
        contacts_next  = contacts_reg;
        if (fire && ev_track)
        begin
            slot_down_next[cur_slot_reg] = track_now;
            if (track_now && !down_cur)
                contacts_next = contacts_reg + CNT_W'(1);
            else if (!track_now && down_cur && contacts_reg != '0)
                contacts_next = contacts_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg  <= '0;
            slot_down_reg <= '0;
            contacts_reg  <= '0;
            x_valid_reg   <= '0;
            y_valid_reg   <= '0;
            rd_xv_reg     <= 1'b0;
            rd_yv_reg     <= 1'b0;
        end
        else
        begin
            cur_slot_reg  <= cur_slot_next;
            slot_down_reg <= slot_down_next;
            contacts_reg  <= contacts_next;
            if (wr_x)
                x_valid_reg[cur_slot_reg] <= 1'b1;
            if (wr_y)
                y_valid_reg[cur_slot_reg] <= 1'b1;
            rd_xv_reg <= wr_x || x_valid_reg[cur_slot_next];
            rd_yv_reg <= wr_y || y_valid_reg[cur_slot_next];
        end
    end

    // Position memories; a write never coincides with a slot change, so the
    // bypass only needs the write strobe.
    always_ff @(posedge clk)
    begin
        if (wr_x)
            slot_x_mem[cur_slot_reg] <= wd_x;
        rd_x_reg <= wr_x ? wd_x : slot_x_mem[cur_slot_next];
    end

    always_ff @(posedge clk)
    begin
        if (wr_y)
            slot_y_mem[cur_slot_reg] <= wd_y;
        rd_y_reg <= wr_y ? wd_y : slot_y_mem[cur_slot_next];
    end

    assign cur_x = rd_xv_reg ? rd_x_reg : 32'sd0;
    assign cur_y = rd_yv_reg ? rd_y_reg : 32'sd0;

    mtsed_map u_map
    (
        .slot_x    (cur_x),
        .slot_y    (cur_y),
        .cfg       (cfg),
        .pointer_x (map_x),
        .pointer_y (map_y)
    );

    assign cnt_ext   = CNT_EXT_W'(contacts_reg);
    assign count_sat = (cnt_ext > CNT_EXT_W'(mtsed_pkg::COUNT_MAX))
                       ? CNT_OUT_W'(mtsed_pkg::COUNT_MAX) : cnt_ext[CNT_OUT_W-1:0];

    // Result register
    assign out_valid_next = (fire && is_report) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && is_report)
        begin
            out_x_reg     <= down_cur ? map_x : '0;
            out_y_reg     <= down_cur ? map_y : '0;
            out_down_reg  <= down_cur;
            out_count_reg <= count_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_down_reg;
    assign m_tdata  = mtsed_pkg::M_TDATA_W'({out_count_reg, out_y_reg, out_x_reg});

    // Checks
    a_contacts_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_down_reg) == int'(contacts_reg))
        else $error("contact count out of step with slot down flags");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cur_slot_reg) < SLOTS)
        else $error("current slot outside table");

    a_report_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_report |=> out_valid_reg)
        else $error("report word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !(fire && is_report) |=> !out_valid_reg)
        else $error("result without report word");

    a_up_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_down_reg |-> out_x_reg == '0 && out_y_reg == '0)
        else $error("released slot reported a position");

endmodule
